// File: hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ST1  = 4'd1,
        PH_ST2  = 4'd2,
        PH_TXA  = 4'd3,
        PH_TXB  = 4'd4,
        PH_TXC  = 4'd5,
        PH_AKA  = 4'd6,
        PH_AKB  = 4'd7,
        PH_GAP  = 4'd8,
        PH_RXA  = 4'd9,
        PH_RXB  = 4'd10,
        PH_RAA  = 4'd11,
        PH_RAB  = 4'd12,
        PH_RAC  = 4'd13,
        PH_SPA  = 4'd14,
        PH_SPB  = 4'd15
    } phase_t;

    localparam logic [2:0]  STEP_ADDR     = 3'd0;
    localparam logic [2:0]  STEP_REG      = 3'd1;
    localparam logic [2:0]  STEP_RESTART  = 3'd2;
    localparam logic [2:0]  STEP_LAST     = 3'd3;
    localparam logic [2:0]  STEP_RX2      = 3'd4;
    localparam logic [15:0] DELAY_RESET   = 16'd20;
    localparam logic [7:0]  READ_BIT      = 8'h01;

    typedef struct packed {
        op_t         op;
        logic [7:0]  slave_byte;
        logic [7:0]  register_index;
        logic [15:0] write_word;
        logic        sda_level;
    } item_t;

    typedef struct packed {
        logic        scl_release;
        logic        sda_release;
        logic        busy_res;
        logic        done_res;
        logic        fail;
        logic [15:0] read_word;
    } result_t;

    function automatic logic [7:0] byte_for_step(
        input logic [2:0]  step,
        input logic        is_read,
        input logic [7:0]  slave,
        input logic [7:0]  regidx,
        input logic [15:0] data
    );
        logic [7:0] b;
        if (step == STEP_ADDR)
            b = slave;
        else if (step == STEP_REG)
            b = regidx;
        else if (is_read)
            b = slave | READ_BIT;
        else if (step == STEP_RESTART)
            b = data[15:8];
        else
            b = data[7:0];
        return b;
    endfunction

endpackage

// File: hw/rtl/i2cm_seq.sv
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [15:0] cfg_value,
    output result_t     result
);

    logic [15:0] delay_ticks_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] delay_reg, delay_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  slave_reg, slave_next;
    logic [7:0]  regidx_reg, regidx_next;
    logic [15:0] data_reg, data_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic [2:0]  step_reg, step_next;
    logic        read_reg, read_next;
    logic        fail_reg, fail_next;
    logic        done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= DELAY_RESET;
            phase_reg       <= PH_IDLE;
            delay_reg       <= '0;
            bit_reg         <= '0;
            shift_reg       <= '0;
            slave_reg       <= '0;
            regidx_reg      <= '0;
            data_reg        <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            step_reg        <= STEP_ADDR;
            read_reg        <= 1'b0;
            fail_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                delay_ticks_reg <= cfg_value;
            phase_reg  <= phase_next;
            delay_reg  <= delay_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            slave_reg  <= slave_next;
            regidx_reg <= regidx_next;
            data_reg   <= data_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            step_reg   <= step_next;
            read_reg   <= read_next;
            fail_reg   <= fail_next;
        end
    end

    always_comb
    begin
        logic [15:0] arm_val;
        logic [2:0]  step_inc;
        logic [3:0]  bit_inc;
        logic [7:0]  shifted;
        logic [7:0]  tx_byte;
        logic        is_cmd;

        arm_val  = (delay_ticks_reg == 16'd0) ? 16'd1 : delay_ticks_reg;
        step_inc = step_reg + 3'd1;
        bit_inc  = bit_reg + 4'd1;
        shifted  = {shift_reg[6:0], 1'b0};
        is_cmd   = (item.op == OP_WRITE) || (item.op == OP_READ);

        phase_next  = phase_reg;
        delay_next  = delay_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        slave_next  = slave_reg;
        regidx_next = regidx_reg;
        data_next   = data_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        step_next   = step_reg;
        read_next   = read_reg;
        fail_next   = fail_reg;
        done        = 1'b0;
        tx_byte     = byte_for_step(step_reg, read_reg, slave_reg, regidx_reg, data_reg);

        if (step_en)
        begin
            if (is_cmd)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    slave_next  = item.slave_byte;
                    regidx_next = item.register_index;
                    read_next   = (item.op == OP_READ);
                    data_next   = (item.op == OP_READ) ? 16'd0 : item.write_word;
                    step_next   = STEP_ADDR;
                    fail_next   = 1'b0;
                    sda_next    = 1'b1;
                    scl_next    = 1'b1;
                    phase_next  = PH_ST1;
                    delay_next  = arm_val;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (delay_reg > 16'd1)
                    delay_next = delay_reg - 16'd1;
                else
                begin
                    delay_next = 16'd0;
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            phase_next = PH_IDLE;
                        end
                        PH_ST1:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_ST2;
                            delay_next = arm_val;
                        end
                        PH_ST2:
                        begin
                            scl_next   = 1'b0;
                            shift_next = tx_byte;
                            bit_next   = 4'd0;
                            sda_next   = tx_byte[7];
                            phase_next = PH_TXA;
                            delay_next = arm_val;
                        end
                        PH_TXA:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_TXB;
                            delay_next = arm_val;
                        end
                        PH_TXB:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_TXC;
                            delay_next = arm_val;
                        end
                        PH_TXC:
                        begin
                            shift_next = shifted;
                            bit_next   = bit_inc;
                            delay_next = arm_val;
                            if (!bit_inc[3])
                            begin
                                sda_next   = shifted[7];
                                phase_next = PH_TXA;
                            end
                            else
                            begin
                                sda_next   = 1'b1;
                                phase_next = PH_AKA;
                            end
                        end
                        PH_AKA:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_AKB;
                            delay_next = arm_val;
                        end
                        PH_AKB:
                        begin
                            scl_next   = 1'b0;
                            delay_next = arm_val;
                            tx_byte    = byte_for_step(step_inc, read_reg, slave_reg,
                                                       regidx_reg, data_reg);
                            if ((!read_reg && step_reg == STEP_LAST) || item.sda_level)
                            begin
                                // last write ack ignored, otherwise a nack fails
                                if (read_reg || step_reg != STEP_LAST)
                                    fail_next = 1'b1;
                                sda_next   = 1'b0;
                                phase_next = PH_SPA;
                            end
                            else
                            begin
                                step_next = step_inc;
                                if (!read_reg || step_inc == STEP_REG)
                                begin
                                    shift_next = tx_byte;
                                    bit_next   = 4'd0;
                                    sda_next   = tx_byte[7];
                                    phase_next = PH_TXA;
                                end
                                else if (step_inc == STEP_RESTART)
                                begin
                                    sda_next   = 1'b1;
                                    scl_next   = 1'b1;
                                    phase_next = PH_ST1;
                                end
                                else
                                    phase_next = PH_GAP;
                            end
                        end
                        PH_GAP:
                        begin
                            sda_next   = 1'b1;
                            shift_next = 8'd0;
                            bit_next   = 4'd0;
                            scl_next   = 1'b1;
                            phase_next = PH_RXA;
                            delay_next = arm_val;
                        end
                        PH_RXA:
                        begin
                            shift_next = shift_reg | {7'd0, item.sda_level};
                            scl_next   = 1'b0;
                            phase_next = PH_RXB;
                            delay_next = arm_val;
                        end
                        PH_RXB:
                        begin
                            bit_next   = bit_inc;
                            delay_next = arm_val;
                            if (!bit_inc[3])
                            begin
                                shift_next = shifted;
                                scl_next   = 1'b1;
                                phase_next = PH_RXA;
                            end
                            else
                            begin
                                if (step_reg == STEP_LAST)
                                begin
                                    data_next = {shift_reg, data_reg[7:0]};
                                    sda_next  = 1'b0;
                                end
                                else
                                begin
                                    data_next = {data_reg[15:8], shift_reg};
                                    sda_next  = 1'b1;
                                end
                                phase_next = PH_RAA;
                            end
                        end
                        PH_RAA:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_RAB;
                            delay_next = arm_val;
                        end
                        PH_RAB:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_RAC;
                            delay_next = arm_val;
                        end
                        PH_RAC:
                        begin
                            delay_next = arm_val;
                            if (step_reg == STEP_LAST)
                            begin
                                step_next  = STEP_RX2;
                                sda_next   = 1'b1;
                                shift_next = 8'd0;
                                bit_next   = 4'd0;
                                scl_next   = 1'b1;
                                phase_next = PH_RXA;
                            end
                            else
                            begin
                                scl_next   = 1'b0;
                                sda_next   = 1'b0;
                                phase_next = PH_SPA;
                            end
                        end
                        PH_SPA:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_SPB;
                            delay_next = arm_val;
                        end
                        PH_SPB:
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        result.scl_release = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.fail        = fail_next;
        result.read_word   = read_next ? data_next : 16'd0;
    end

endmodule

// File: hw/rtl/i2c_master_register_access.sv
// channel   dir  beat fields (low bit up)                                    handshake
// s_axis    in   tuser: op; tdata: slave_byte, register_index, write_word,   tvalid/tready
//                sda_level
// m_axis    out  tdata: scl_release, sda_release, busy_res, done_res, fail,  tvalid/tready
//                read_word
// cfg       in   cfg_data: delay_ticks                                       cfg_valid/cfg_ready
//
// one beat per cycle unless m_axis stalls; an accepted beat waits in the input register;
// when it moves on, the sequencer state updates and its result is registered onto m_axis
// rst_n clears sequencer and valid flags: idle, both lines released, delay_ticks back to 20
// a stalled m_axis holds its beat; s_axis keeps accepting until the input register is full
// cfg is always ready and takes effect on the next beat
module i2c_master_register_access
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // op
    input  logic [39:0] s_axis_tdata,  // slave_byte, register_index, write_word, sda_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // scl_release, sda_release, busy_res, done_res, fail,
                                       // read_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    logic    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.op             <= op_t'(s_axis_tuser);
            in_item_reg.slave_byte     <= s_axis_tdata[7:0];
            in_item_reg.register_index <= s_axis_tdata[15:8];
            in_item_reg.write_word     <= s_axis_tdata[31:16];
            in_item_reg.sda_level      <= s_axis_tdata[32];
        end
        if (advance)
            out_reg <= result;
    end

    i2cm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .item      (in_item_reg),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .result    (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_reg.read_word, out_reg.fail, out_reg.done_res,
                            out_reg.busy_res, out_reg.sda_release, out_reg.scl_release};

endmodule

// File: hw/rtl/i2cm_checker.sv
module i2cm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // finishing beat is no longer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done while busy");

    // bus is released on both lines whenever idle
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[0] && m_axis_tdata[1])
        else $error("idle with a line pulled low");

    // pad bits above read_word stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:21] == 3'd0)
        else $error("pad bits set");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled beat changed");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/i2c_master_register_access_test.sv
`timescale 1ns / 1ps

module i2c_master_register_access_test;
    import i2cm_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser = OP_TICK;   // op
    logic [39:0] s_axis_tdata = '0;        // slave_byte, register_index, write_word, sda_level
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;             // scl_release, sda_release, busy_res, done_res,
                                           // fail, read_word
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    i2c_master_register_access uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // bus sequencer mirror
    logic [15:0] tick_len = DELAY_RESET;
    phase_t      ph = PH_IDLE;
    logic [15:0] dly_left = '0;
    logic [3:0]  bit_idx = '0;
    logic [7:0]  shifter = '0;
    logic [7:0]  dev_addr = '0;
    logic [7:0]  index_byte = '0;
    logic [15:0] data_word = '0;
    logic        scl_out = 1'b1;
    logic        sda_out = 1'b1;
    logic [2:0]  seq_step = STEP_ADDR;
    logic        rd_mode = 1'b0;
    logic        nack_seen = 1'b0;

    result_t     bus_expect[$];
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    int          rx_stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic void arm_delay(input phase_t next_ph);
        ph = next_ph;
        dly_left = (tick_len == 16'd0) ? 16'd1 : tick_len;
    endfunction

    function automatic void start_cond();
        sda_out = 1'b1;
        scl_out = 1'b1;
        arm_delay(PH_ST1);
    endfunction

    function automatic void stop_cond();
        scl_out = 1'b0;
        sda_out = 1'b0;
        arm_delay(PH_SPA);
    endfunction

    function automatic void load_tx();
        case (seq_step)
            STEP_ADDR: shifter = dev_addr;
            STEP_REG:  shifter = index_byte;
            default:   shifter = rd_mode ? (dev_addr | READ_BIT)
                                 : (seq_step == STEP_RESTART) ? data_word[15:8] : data_word[7:0];
        endcase
        bit_idx = '0;
        sda_out = shifter[7];
        arm_delay(PH_TXA);
    endfunction

    function automatic void load_rx();
        sda_out = 1'b1;
        shifter = '0;
        bit_idx = '0;
        scl_out = 1'b1;
        arm_delay(PH_RXA);
    endfunction

    function automatic logic clock_bus(input logic sda_in);
        logic finished;
        finished = 1'b0;
        if (ph == PH_IDLE)
            return 1'b0;
        if (dly_left > 16'd1)
        begin
            dly_left--;
            return 1'b0;
        end
        dly_left = '0;
        case (ph)
            PH_ST1:
            begin
                sda_out = 1'b0;
                arm_delay(PH_ST2);
            end
            PH_ST2:
            begin
                scl_out = 1'b0;
                load_tx();
            end
            PH_TXA:
            begin
                scl_out = 1'b1;
                arm_delay(PH_TXB);
            end
            PH_TXB:
            begin
                scl_out = 1'b0;
                arm_delay(PH_TXC);
            end
            PH_TXC:
            begin
                shifter = shifter << 1;
                bit_idx++;
                if (bit_idx < 4'd8)
                begin
                    sda_out = shifter[7];
                    arm_delay(PH_TXA);
                end
                else
                begin
                    sda_out = 1'b1;
                    arm_delay(PH_AKA);
                end
            end
            PH_AKA:
            begin
                scl_out = 1'b1;
                arm_delay(PH_AKB);
            end
            PH_AKB:
            begin
                scl_out = 1'b0;
                if (!rd_mode && seq_step == STEP_LAST)
                    stop_cond();
                else if (sda_in)
                begin
                    nack_seen = 1'b1;
                    stop_cond();
                end
                else
                begin
                    seq_step++;
                    if (!rd_mode || seq_step == STEP_REG)
                        load_tx();
                    else if (seq_step == STEP_RESTART)
                        start_cond();
                    else
                        arm_delay(PH_GAP);
                end
            end
            PH_GAP: load_rx();
            PH_RXA:
            begin
                if (sda_in)
                    shifter[0] = 1'b1;
                scl_out = 1'b0;
                arm_delay(PH_RXB);
            end
            PH_RXB:
            begin
                bit_idx++;
                if (bit_idx < 4'd8)
                begin
                    shifter = shifter << 1;
                    scl_out = 1'b1;
                    arm_delay(PH_RXA);
                end
                else
                begin
                    if (seq_step == STEP_LAST)
                        data_word[15:8] = shifter;
                    else
                        data_word[7:0] = shifter;
                    sda_out = (seq_step == STEP_LAST) ? 1'b0 : 1'b1;
                    arm_delay(PH_RAA);
                end
            end
            PH_RAA:
            begin
                scl_out = 1'b1;
                arm_delay(PH_RAB);
            end
            PH_RAB:
            begin
                scl_out = 1'b0;
                arm_delay(PH_RAC);
            end
            PH_RAC:
            begin
                sda_out = 1'b1;
                if (seq_step == STEP_LAST)
                begin
                    seq_step = STEP_RX2;
                    load_rx();
                end
                else
                    stop_cond();
            end
            PH_SPA:
            begin
                scl_out = 1'b1;
                arm_delay(PH_SPB);
            end
            PH_SPB:
            begin
                sda_out = 1'b1;
                ph = PH_IDLE;
                finished = 1'b1;
            end
            default: ph = PH_IDLE;
        endcase
        return finished;
    endfunction

    function automatic result_t next_bus_state(input op_t op, input logic [7:0] dev,
                                               input logic [7:0] ra, input logic [15:0] wd,
                                               input logic sda);
        result_t r;
        logic    finished;
        finished = 1'b0;
        if (op == OP_WRITE || op == OP_READ)
        begin
            if (ph == PH_IDLE)
            begin
                dev_addr = dev;
                index_byte = ra;
                rd_mode = (op == OP_READ);
                data_word = rd_mode ? 16'd0 : wd;
                seq_step = STEP_ADDR;
                nack_seen = 1'b0;
                start_cond();
            end
        end
        else
            finished = clock_bus(sda);
        r.scl_release = scl_out;
        r.sda_release = sda_out;
        r.busy_res = (ph != PH_IDLE);
        r.done_res = finished;
        r.fail = nack_seen;
        r.read_word = rd_mode ? data_word : 16'd0;
        return r;
    endfunction

    // slave acks unless told to refuse this byte; read bits rx_mode[0] if not 2, else random
    function automatic logic slave_sda(input int nack_step, input int rx_mode);
        if (ph == PH_AKB && dly_left <= 16'd1)
            return (nack_step >= 0 && int'(seq_step) == nack_step);
        if (ph == PH_RXA && dly_left <= 16'd1 && rx_mode != 2)
            return rx_mode[0];
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic op_t tick_op();
        return ($urandom_range(0, 15) == 0) ? OP_SPARE : OP_TICK;
    endfunction

    task automatic send_item(input op_t op, input logic [7:0] dev, input logic [7:0] ra,
                             input logic [15:0] wd, input logic sda);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = draw_gap();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, sda, wd, ra, dev};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bus_expect.push_back(next_bus_state(op, dev, ra, wd, sda));
    endtask

    task automatic send_tick(input int nack_step, input int rx_mode);
        send_item(tick_op(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), slave_sda(nack_step, rx_mode));
    endtask

    task automatic tick_until_idle(input int nack_step, input int rx_mode);
        while (ph != PH_IDLE)
            send_tick(nack_step, rx_mode);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (bus_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_delay(input logic [15:0] ticks);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= ticks;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tick_len = ticks;
    endtask

    task automatic test_reset_delay();
        send_item(OP_WRITE, 8'hA4, 8'h5A, 16'hFFFF, 1'b0);
        // command while busy is dropped
        send_item(OP_READ, 8'h5B, 8'hA5, 16'h0000, 1'b1);
        repeat (25)
            send_tick(-1, 2);
        set_delay(16'd1);
        tick_until_idle(-1, 2);
    endtask

    task automatic test_zero_delay();
        set_delay(16'd0);
        send_item(OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b1);
        send_item(OP_SPARE, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
        send_item(OP_READ, 8'hFF, 8'h00, 16'hFFFF, 1'b1);
        tick_until_idle(-1, 1);
        send_item(OP_READ, 8'h00, 8'hFF, 16'hFFFF, 1'b0);
        tick_until_idle(-1, 0);
    endtask

    task automatic test_nack_cases();
        set_delay(16'd1);
        // no ack after the last write byte is not a failure
        send_item(OP_WRITE, 8'h00, 8'hFF, 16'h0000, 1'b0);
        tick_until_idle(int'(STEP_LAST), 2);
        send_item(OP_WRITE, 8'hFE, 8'h01, 16'h8001, 1'b1);
        tick_until_idle(int'(STEP_ADDR), 2);
        send_item(OP_READ, 8'h7E, 8'h80, 16'h1234, 1'b0);
        tick_until_idle(int'(STEP_REG), 2);
        send_item(OP_READ, 8'h42, 8'h3C, 16'h0000, 1'b0);
        tick_until_idle(int'(STEP_RESTART), 2);
        send_item(OP_WRITE, 8'h3C, 8'h42, 16'hA55A, 1'b0);
        tick_until_idle(int'(STEP_RESTART), 2);
    endtask

    task automatic test_long_delay();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        set_delay(16'd32);
        send_item(OP_WRITE, 8'h96, 8'h69, 16'hC33C, 1'b0);
        repeat (36)
            send_tick(-1, 2);
        set_delay(16'd1);
        tick_until_idle(-1, 2);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_request = 1'b1;
        send_item(OP_READ, 8'hB4, 8'h4B, 16'h0000, 1'b0);
        tick_until_idle(-1, 2);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic(input logic [15:0] ticks, input int count);
        op_t op;
        set_delay(ticks);
        repeat (count)
        begin
            if (ph == PH_IDLE)
                op = ($urandom_range(0, 9) < 7) ? op_t'($urandom_range(1, 2))
                                                 : op_t'($urandom_range(0, 3));
            else
                op = ($urandom_range(0, 39) == 0) ? op_t'($urandom_range(1, 2)) : tick_op();
            send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)),
                      slave_sda(($urandom_range(0, 9) == 0) ? int'(seq_step) : -1, 2));
        end
        tick_until_idle(-1, 2);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_beat(input logic [23:0] beat);
        result_t got;
        result_t want;
        got.scl_release = beat[0];
        got.sda_release = beat[1];
        got.busy_res = beat[2];
        got.done_res = beat[3];
        got.fail = beat[4];
        got.read_word = beat[20:5];
        if (bus_expect.size() == 0)
        begin
            errors++;
            $display("%0t unexpected beat: expected none actual %h", $time, beat);
        end
        else
        begin
            want = bus_expect.pop_front();
            compare_field("scl_release", want.scl_release, got.scl_release);
            compare_field("sda_release", want.sda_release, got.sda_release);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("fail", want.fail, got.fail);
            compare_field("read_word", want.read_word, got.read_word);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_beat(m_axis_tdata);
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rx_gaps_on && $urandom_range(0, 3) == 0)
                rx_stall_left = draw_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_delay();
        test_zero_delay();
        test_nack_cases();
        test_long_delay();
        test_backpressure();
        test_random_traffic(16'd1, 80);
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
